@@ rtl/teva_pkg.sv @@
package teva_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TRACKS = 8;

  // queue occupancy counter must be able to hold the depth itself
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int TIW = (TRACKS > 1) ? $clog2(TRACKS) : 1;

  typedef enum logic [1:0] {
    CMD_QUEUE = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_STOP  = 2'd2
  } cmd_e;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] touch_id;
    logic [15:0] delay_ticks;
    logic        fade_out;
    logic [31:0] payload;
  } item_t;

  typedef struct packed {
    logic [TIW-1:0] track_index;
    logic [15:0]    out_touch_id;
    logic [31:0]    out_payload;
    logic           out_fade_out;
    logic           dropped;
    logic           last;
  } result_t;

  typedef struct packed {
    logic [15:0] touch;
    logic [15:0] delay;
    logic        fade;
    logic [31:0] data;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  typedef struct packed {
    logic        valid;
    logic        clear;
    logic [15:0] touch;
    logic        fade;
  } disp_req_t;

  typedef struct packed {
    logic [TIW-1:0] index;
    logic           dropped;
  } disp_rsp_t;

endpackage

@@ rtl/teva_cell.sv @@
module teva_cell (
  input  logic              clk,
  input  teva_pkg::cell_ctl_t ctl,
  input  teva_pkg::entry_t  right,
  input  teva_pkg::entry_t  load_data,
  output teva_pkg::entry_t  q
);
  import teva_pkg::*;

  // a load wins over the shift: it places the appended entry behind the shifted ones
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q <= load_data;
    end else if (ctl.shift) begin
      q <= right;
    end
  end

endmodule

@@ rtl/teva_tracks.sv @@
module teva_tracks (
  input  logic                clk,
  input  logic                rst,
  input  teva_pkg::disp_req_t req,
  output teva_pkg::disp_rsp_t rsp
);
  import teva_pkg::*;

  logic [15:0]    owner [TRACKS];
  logic           hit;
  logic           free;
  logic [TIW-1:0] hit_idx;
  logic [TIW-1:0] free_idx;

  always_comb begin
    hit      = 1'b0;
    free     = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int t = 0; t < TRACKS; t++) begin
      if (!hit && owner[t] == req.touch) begin
        hit     = 1'b1;
        hit_idx = TIW'(t);
      end
      if (!free && owner[t] == 16'd0) begin
        free     = 1'b1;
        free_idx = TIW'(t);
      end
    end
    rsp.dropped = !hit && !free;
    priority if (hit) begin
      rsp.index = hit_idx;
    end else if (free) begin
      rsp.index = free_idx;
    end else begin
      rsp.index = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      for (int t = 0; t < TRACKS; t++) begin
        owner[t] <= 16'd0;
      end
    end else if (req.valid && !rsp.dropped) begin
      // a fade-out hands the track straight back
      owner[rsp.index] <= req.fade ? 16'd0 : req.touch;
    end
  end

endmodule

@@ rtl/timed_event_voice_allocator_unit.sv @@
// queue and stop take effect at the accepting edge, busy stays low
// a tick keeps busy high through the walk over the queued entries (at most 16) and its closing step;
// the row of queue cells moves one entry past the track lookup per cycle
// a result is held until the next dispatch or the end of the walk, so the last one of a
// tick shows in the first cycle with busy low again
// reset (rst, synchronous) empties the queue and frees every track; queue contents are not cleared
module timed_event_voice_allocator_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  teva_pkg::item_t   item,
  output logic              strobe,
  output teva_pkg::result_t result
);
  import teva_pkg::*;

  state_t          state;
  state_t          state_next;
  logic [QCW-1:0]  count;
  logic [QCW-1:0]  occ;
  logic [QCW-1:0]  remain;
  logic            pend_valid;
  result_t         pend;

  entry_t          cell_q   [QUEUE_DEPTH];
  entry_t          cell_right [QUEUE_DEPTH];
  cell_ctl_t       cell_ctl [QUEUE_DEPTH];
  entry_t          load_data;
  logic            load_en;
  logic [QCW-1:0]  load_idx;
  logic            shift_all;
  logic            accept;
  entry_t          head;
  disp_req_t       req;
  disp_rsp_t       rsp;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);
  assign head   = cell_q[0];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign cell_right[i] = cell_q[i];
    end else begin : g_mid
      assign cell_right[i] = cell_q[i+1];
    end
    assign cell_ctl[i].shift = shift_all;
    assign cell_ctl[i].load  = load_en && (load_idx == QCW'(i));

    teva_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[i]),
      .right     (cell_right[i]),
      .load_data (load_data),
      .q         (cell_q[i])
    );
  end

  teva_tracks u_tracks (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_comb begin
    state_next = state;
    shift_all  = 1'b0;
    load_en    = 1'b0;
    load_idx   = '0;
    load_data  = '{touch: item.touch_id, delay: item.delay_ticks,
                   fade: item.fade_out, data: item.payload};
    req        = '{valid: 1'b0, clear: 1'b0, touch: head.touch, fade: head.fade};
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority case (item.cmd)
            CMD_QUEUE: begin
              load_en = 1'b1;
              if (count == QCW'(QUEUE_DEPTH)) begin
                // full: oldest falls out of cell zero, new one enters at the tail
                shift_all = 1'b1;
                load_idx  = QCW'(QUEUE_DEPTH - 1);
              end else begin
                load_idx = count;
              end
            end
            CMD_TICK: state_next = ST_WALK;
            CMD_STOP: req.clear = 1'b1;
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        if (remain != '0) begin
          shift_all = 1'b1;
          if (head.delay != 16'd0) begin
            // survivor goes back in behind everything still occupied
            load_en   = 1'b1;
            load_idx  = occ - QCW'(1);
            load_data = '{touch: head.touch, delay: head.delay - 16'd1,
                          fade: head.fade, data: head.data};
          end else begin
            req.valid = 1'b1;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      occ        <= '0;
      remain     <= '0;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (state == ST_IDLE) begin
        if (accept && item.cmd == CMD_QUEUE && count != QCW'(QUEUE_DEPTH)) begin
          count <= count + QCW'(1);
        end
        if (accept && item.cmd == CMD_TICK) begin
          occ    <= count;
          remain <= count;
        end
      end else if (remain != '0) begin
        remain <= remain - QCW'(1);
        if (req.valid) begin
          occ        <= occ - QCW'(1);
          // the previous dispatch is known not to be the last one now
          strobe     <= pend_valid;
          pend_valid <= 1'b1;
        end
      end else begin
        count      <= occ;
        strobe     <= pend_valid;
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_WALK) begin
      if (remain != '0) begin
        if (req.valid) begin
          result <= pend;
          pend   <= '{track_index: rsp.index, out_touch_id: head.touch,
                      out_payload: head.data, out_fade_out: head.fade,
                      dropped: rsp.dropped, last: 1'b0};
        end
      end else begin
        result <= '{track_index: pend.track_index, out_touch_id: pend.out_touch_id,
                    out_payload: pend.out_payload, out_fade_out: pend.out_fade_out,
                    dropped: pend.dropped, last: 1'b1};
      end
    end
  end

endmodule

@@ rtl/teva_checker.sv @@
module teva_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input teva_pkg::item_t   item,
  input logic              strobe,
  input teva_pkg::result_t result
);
  import teva_pkg::*;

  // results only come out of a tick walk
  a_strobe_in_tick: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result outside a tick");

  a_no_result_after_cmd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.cmd != CMD_TICK) |=> !strobe)
    else $error("result after a queue or stop transfer");

  a_drop_track_zero: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.dropped) |-> (result.track_index == '0))
    else $error("dropped event carries a track");

  // a new tick may be taken alongside the last result, but no result follows it at once
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last) |=> !strobe)
    else $error("result right after the last result of a tick");

  a_busy_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && item.cmd == CMD_TICK))
    else $error("busy without a tick transfer");

endmodule

bind timed_event_voice_allocator_unit teva_checker u_teva_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .strobe (strobe),
  .result (result)
);

@@ bench/tb_timed_event_voice_allocator_unit.sv @@
`timescale 1ns / 100ps

class dispatch_model;
  bit [15:0] ev_touch [teva_pkg::QUEUE_DEPTH];
  bit [15:0] ev_delay [teva_pkg::QUEUE_DEPTH];
  bit        ev_fade  [teva_pkg::QUEUE_DEPTH];
  bit [31:0] ev_data  [teva_pkg::QUEUE_DEPTH];
  int unsigned head;
  int unsigned count;
  bit [15:0] owner [teva_pkg::TRACKS];
  teva_pkg::result_t due[$];
  int errors;

  // owned track first, else first free one; touch zero never claims
  function teva_pkg::result_t route(bit [15:0] touch, bit [31:0] data, bit fade);
    teva_pkg::result_t r;
    int found;
    found = -1;
    r = '0;
    r.out_touch_id = touch;
    r.out_payload = data;
    r.out_fade_out = fade;
    for (int t = 0; t < teva_pkg::TRACKS; t++)
      if (found < 0 && owner[t] == touch) found = t;
    if (found < 0) begin
      for (int t = 0; t < teva_pkg::TRACKS; t++)
        if (found < 0 && owner[t] == 16'd0) found = t;
      if (found < 0) begin
        r.dropped = 1'b1;
        return r;
      end
      owner[found] = touch;
    end
    r.track_index = found[teva_pkg::TIW-1:0];
    if (fade) owner[found] = 16'd0;
    return r;
  endfunction

  function void note_transfer(teva_pkg::item_t it);
    int unsigned slot;
    int unsigned src;
    int unsigned dst;
    int unsigned kept;
    teva_pkg::result_t burst[$];
    teva_pkg::result_t r;
    kept = 0;
    case (it.cmd)
      teva_pkg::CMD_QUEUE: begin
        slot = (head + count) % teva_pkg::QUEUE_DEPTH;
        ev_touch[slot] = it.touch_id;
        ev_delay[slot] = it.delay_ticks;
        ev_fade[slot] = it.fade_out;
        ev_data[slot] = it.payload;
        // full queue: the newest entry takes the place of the oldest
        if (count >= teva_pkg::QUEUE_DEPTH) head = (head + 1) % teva_pkg::QUEUE_DEPTH;
        else count++;
      end
      teva_pkg::CMD_TICK: begin
        for (int unsigned i = 0; i < count; i++) begin
          src = (head + i) % teva_pkg::QUEUE_DEPTH;
          if (ev_delay[src] == 16'd0) begin
            burst.push_back(route(ev_touch[src], ev_data[src], ev_fade[src]));
          end else begin
            // survivors close up towards the head in their old order
            dst = (head + kept) % teva_pkg::QUEUE_DEPTH;
            ev_touch[dst] = ev_touch[src];
            ev_delay[dst] = ev_delay[src] - 16'd1;
            ev_fade[dst] = ev_fade[src];
            ev_data[dst] = ev_data[src];
            kept++;
          end
        end
        count = kept;
        if (burst.size() > 0) begin
          r = burst.pop_back();
          r.last = 1'b1;
          burst.push_back(r);
        end
        foreach (burst[k]) due.push_back(burst[k]);
      end
      teva_pkg::CMD_STOP: begin
        foreach (owner[t]) owner[t] = 16'd0;
      end
      default: ;
    endcase
  endfunction

  function void compare_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endfunction

  function void check_dispatch(teva_pkg::result_t got);
    teva_pkg::result_t want;
    if (due.size() == 0) begin
      $error("dispatch with none expected: track %0d touch %0h", got.track_index,
             got.out_touch_id);
      errors++;
      return;
    end
    want = due.pop_front();
    compare_field("track_index", want.track_index, got.track_index);
    compare_field("out_touch_id", want.out_touch_id, got.out_touch_id);
    compare_field("out_payload", want.out_payload, got.out_payload);
    compare_field("out_fade_out", want.out_fade_out, got.out_fade_out);
    compare_field("dropped", want.dropped, got.dropped);
    compare_field("last", want.last, got.last);
  endfunction

  function int pending();
    return due.size();
  endfunction
endclass

module tb_timed_event_voice_allocator_unit;
  import teva_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 200;
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_ITEMS = 220;
  localparam int QUIET_TAIL = 40;

  logic    clk;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  item_t   item = '0;
  logic    strobe;
  result_t result;

  dispatch_model model = new;
  int stall_cycles = 0;
  int idle_odds = 0;
  bit quiet = 1'b0;
  bit paused = 1'b0;
  int sent = 0;

  timed_event_voice_allocator_unit DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .strobe(strobe),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (strobe) model.check_dispatch(result);
      if (start && !busy) model.note_transfer(item);
      if (strobe || (start && !busy)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic send(item_t it);
    item <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic rest(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic maybe_rest();
    if (!quiet && $urandom_range(0, 7) < idle_odds) rest($urandom_range(1, 4));
  endtask

  // start drops and the clock advances before polling, so the last transfer has reached the scoreboard
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (model.pending() != 0) @(posedge clk);
  endtask

  function automatic item_t queued_item(bit [15:0] touch, bit [15:0] delay, bit fade,
                                        bit [31:0] data);
    item_t it;
    it.cmd = CMD_QUEUE;
    it.touch_id = touch;
    it.delay_ticks = delay;
    it.fade_out = fade;
    it.payload = data;
    return it;
  endfunction

  // fields other than cmd are noise here
  function automatic item_t control_item(logic [1:0] code);
    item_t it;
    it.cmd = code;
    it.touch_id = 16'($urandom);
    it.delay_ticks = 16'($urandom);
    it.fade_out = 1'($urandom);
    it.payload = $urandom;
    return it;
  endfunction

  // a small pool of touches keeps tracks contended
  function automatic bit [15:0] pick_touch();
    case ($urandom_range(0, 31))
      0: return 16'd0;
      1, 2: return 16'($urandom);
      default: return 16'($urandom_range(1, 10));
    endcase
  endfunction

  function automatic bit [15:0] pick_delay();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 16'd0;
    if (r < 16) return 16'($urandom_range(1, 3));
    if (r < 18) return 16'($urandom_range(4, 12));
    if (r == 18) return 16'($urandom_range(0, 65535));
    return 16'hFFFF;
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send(control_item(CMD_TICK));
    send(queued_item(16'd1, 16'd0, 1'b0, 32'h0000_0000));
    send(queued_item(16'hFFFF, 16'd1, 1'b1, 32'hFFFF_FFFF));
    send(queued_item(16'd0, 16'd0, 1'b0, 32'h5A5A_A5A5));
    send(control_item(CMD_TICK));
    send(control_item(CMD_TICK));
    // more touches than tracks, so the tail gets dropped
    for (int k = 2; k <= 10; k++) send(queued_item(16'(16'h0100 + k), 16'd0, 1'b0, $urandom));
    send(queued_item(16'd1, 16'd0, 1'b1, 32'hC0DE_0001));
    send(control_item(CMD_TICK));
    send(control_item(CMD_UNUSED));
    send(control_item(CMD_STOP));
    send(queued_item(16'h8000, 16'hFFFF, 1'b0, 32'h8000_0001));
    send(queued_item(16'h7FFF, 16'd0, 1'b0, 32'h7FFF_FFFE));
    send(control_item(CMD_TICK));

    while (sent < RANDOM_ITEMS) begin
      quiet = (sent >= RANDOM_ITEMS - QUIET_TAIL);
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        drain();
        paused = 1'b1;
      end
      idle_odds = $urandom_range(0, 3);
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 6))
          begin
        maybe_rest();
        send(queued_item(pick_touch(), pick_delay(), $urandom_range(0, 3) == 0, $urandom));
        sent++;
      end
      repeat ($urandom_range(1, 3)) begin
        maybe_rest();
        send(control_item(CMD_TICK));
        sent++;
      end
      case ($urandom_range(0, 15))
        0: begin
          send(control_item(CMD_STOP));
          sent++;
        end
        1: send(control_item(CMD_UNUSED));
        default: ;
      endcase
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (model.errors == 0 && model.pending() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/teva_pkg.sv
rtl/teva_cell.sv
rtl/teva_tracks.sv
rtl/timed_event_voice_allocator_unit.sv
rtl/teva_checker.sv
bench/tb_timed_event_voice_allocator_unit.sv
